>>> src/assert_macros.svh
// Assertion helpers for the sorter design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SKT_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

  typedef logic signed [31:0] key_t;
  typedef logic [6:0]         tag_t;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_EMIT   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast from the control to every cell
  typedef struct packed {
    logic ins;
    logic emit;
    key_t key;
    tag_t tag;
  } skt_ctrl_t;

  // Handed from each cell to its neighbors on both sides
  typedef struct packed {
    logic gt;
    logic occ;
    key_t key;
    tag_t tag;
  } skt_link_t;

endpackage

>>> src/skt_req_if.sv
`timescale 1ns / 1ps

interface skt_req_if;
  import skt_pkg::*;

  logic valid;
  logic ready;
  logic req_type;
  key_t sort_key;
  tag_t tag_in;

  modport source (output valid, output req_type, output sort_key, output tag_in,
                  input ready);
  modport sink   (input valid, input req_type, input sort_key, input tag_in,
                  output ready);
endinterface

>>> src/skt_rsp_if.sv
`timescale 1ns / 1ps

interface skt_rsp_if;
  import skt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  key_t    key_out;
  tag_t    tag_out;
  logic    last_out;

  modport source (output valid, output status, output key_out, output tag_out,
                  output last_out, input ready);
  modport sink   (input valid, input status, input key_out, input tag_out,
                  input last_out, output ready);
endinterface

>>> src/skt_cell.sv
`timescale 1ns / 1ps

module skt_cell (
  input  logic              clk,
  input  skt_pkg::skt_ctrl_t ctrl,
  input  logic              occ,
  input  skt_pkg::skt_link_t left,
  input  skt_pkg::skt_link_t right,
  output skt_pkg::skt_link_t link
);
  import skt_pkg::*;

  key_t key;
  tag_t tag;
  key_t key_next;
  tag_t tag_next;
  logic gt;

  // Strictly greater keeps equal keys in arrival order
  assign gt = occ && (key > ctrl.key);

  always_comb begin
    key_next = key;
    tag_next = tag;
    if (ctrl.ins) begin
      if (left.gt) begin
        key_next = left.key;
        tag_next = left.tag;
      end else if (gt || (!occ && left.occ)) begin
        key_next = ctrl.key;
        tag_next = ctrl.tag;
      end
    end else if (ctrl.emit) begin
      key_next = right.key;
      tag_next = right.tag;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

  assign link = '{gt: gt, occ: occ, key: key, tag: tag};

endmodule

>>> src/stable_key_tag_sorter.sv
`timescale 1ns / 1ps
// Each result is registered as its request beat is accepted. One request per
// cycle is taken unless results stall; every cell compares its key with the new
// key in parallel and shifts by at most one place, so each beat is a single step.
// Reset clears the fill count and the result valid; cell contents stay undefined.

module stable_key_tag_sorter #(
  parameter int CAPACITY = 128
) (
  input logic      clk,
  input logic      rst,
  skt_req_if.sink  req,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  logic          accept;
  skt_ctrl_t     ctrl;
  skt_link_t     link [0:CAPACITY+1];

  logic    rsp_valid;
  status_t rsp_status;
  key_t    rsp_key;
  tag_t    rsp_tag;
  logic    rsp_last;
  status_t status_next;
  key_t    key_next;
  tag_t    tag_next;
  logic    last_next;

  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);
  assign accept = req.valid && req.ready;

  // Output register frees the input whenever its beat is taken
  assign req.ready = !rsp_valid || rsp.ready;

  assign ctrl.ins  = accept && (req.req_type == REQ_INSERT) && !full;
  assign ctrl.emit = accept && (req.req_type == REQ_EMIT) && !empty;
  assign ctrl.key  = req.sort_key;
  assign ctrl.tag  = req.tag_in;

  // Chain ends: left edge acts as an occupied cell that is never greater
  assign link[0]          = '{gt: 1'b0, occ: 1'b1, key: '0, tag: '0};
  assign link[CAPACITY+1] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    assign occ = (CW'(i) < count);
    skt_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .occ   (occ),
      .left  (link[i]),
      .right (link[i+2]),
      .link  (link[i+1])
    );
  end

  // Fill count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.emit) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result of the current request
  always_comb begin
    status_next = ST_OK;
    key_next    = '0;
    tag_next    = '0;
    last_next   = 1'b0;
    if (req.req_type == REQ_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else begin
      key_next  = link[1].key;
      tag_next  = link[1].tag;
      last_next = (count == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req.ready) begin
      rsp_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_key    <= key_next;
      rsp_tag    <= tag_next;
      rsp_last   <= last_next;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.key_out  = rsp_key;
  assign rsp.tag_out  = rsp_tag;
  assign rsp.last_out = rsp_last;

  // Checks
  `SKT_ASSERT(a_count_bound, count <= CW'(CAPACITY), "fill count above capacity")
  `SKT_ASSERT(a_head_sorted, (count < CW'(2)) || (link[1].key <= link[2].key), "head out of order")
  `SKT_ASSERT_NEXT(a_ins_count, ctrl.ins, count == $past(count) + CW'(1), "insert did not count")
  `SKT_ASSERT_NEXT(a_emit_ok, ctrl.emit, rsp_valid && (rsp_status == ST_OK), "emit lost its result")

endmodule

>>> bench/tb_stable_key_tag_sorter.sv
`timescale 1ns / 1ps

module tb_stable_key_tag_sorter;
  import skt_pkg::*;

  localparam int CAP = 128;
  localparam int CYCLE_LIMIT = 200000;
  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic req_type;
    key_t key;
    tag_t tag;
    bit   hold;     // wait for all results before going on
    bit   no_gap;   // no idling on either side around this beat
  } request_t;

  typedef struct {
    status_t status;
    key_t    key;
    tag_t    tag;
    logic    last;
  } result_t;

  typedef struct {
    key_t key;
    tag_t tag;
  } pair_t;

  logic clk;
  logic rst;

  skt_req_if req_if ();
  skt_rsp_if rsp_if ();

  stable_key_tag_sorter #(.CAPACITY(CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  request_t pend_q[$];
  result_t  pending_results[$];
  pair_t    held_pairs[$];
  request_t cur_req;
  int       gap_cnt;
  bit       sink_calm;
  int       stall_cnt;
  int       stall_draw;
  int       fail_cnt;
  int       cycle_cnt;
  int       n_items;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sorted store: insert after every key less than or equal, emit from the front
  function automatic result_t sorter_response(request_t r);
    result_t res;
    int      pos;
    pair_t   p;
    res.status = ST_OK;
    res.key    = '0;
    res.tag    = '0;
    res.last   = 1'b0;
    if (r.req_type == REQ_INSERT) begin
      if (held_pairs.size() >= CAP) begin
        res.status = ST_FULL;
      end else begin
        pos = held_pairs.size();
        while (pos > 0 && held_pairs[pos-1].key > r.key) pos--;
        p.key = r.key;
        p.tag = r.tag;
        held_pairs.insert(pos, p);
      end
    end else if (held_pairs.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      p = held_pairs.pop_front();
      res.key  = p.key;
      res.tag  = p.tag;
      res.last = (held_pairs.size() == 0);
    end
    return res;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      gap_cnt      <= 0;
      sink_calm    <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        pending_results.push_back(sorter_response(cur_req));
      if (!req_if.valid || req_if.ready) begin
        if (gap_cnt != 0) begin
          req_if.valid <= 1'b0;
          gap_cnt      <= gap_cnt - 1;
        end else if (pend_q.size() != 0 && pend_q[0].hold) begin
          req_if.valid <= 1'b0;
          if (pending_results.size() == 0) void'(pend_q.pop_front());
        end else if (pend_q.size() != 0) begin
          cur_req = pend_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= cur_req.req_type;
          req_if.sort_key <= cur_req.key;
          req_if.tag_in   <= cur_req.tag;
          sink_calm       <= cur_req.no_gap;
          gap_cnt         <= cur_req.no_gap ? 0 : $urandom_range(0, 8);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_cnt    <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result beat with nothing expected: st=%0d key=%0d tag=%0d last=%0b",
                   $realtime, rsp_if.status, rsp_if.key_out, rsp_if.tag_out,
                   rsp_if.last_out);
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (rsp_if.status !== e.status || rsp_if.key_out !== e.key ||
            rsp_if.tag_out !== e.tag || rsp_if.last_out !== e.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: mismatch exp st=%0d key=%0d tag=%0d last=%0b, got st=%0d key=%0d tag=%0d last=%0b",
                     $realtime, e.status, e.key, e.tag, e.last, rsp_if.status,
                     rsp_if.key_out, rsp_if.tag_out, rsp_if.last_out);
        end
      end
      stall_draw = sink_calm ? 0 : $urandom_range(0, 8);
      stall_cnt    <= stall_draw;
      rsp_if.ready <= (stall_draw == 0);
    end else if (stall_cnt != 0) begin
      stall_cnt    <= stall_cnt - 1;
      rsp_if.ready <= (stall_cnt == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_insert(key_t k, tag_t t, bit calm);
    request_t r;
    r.req_type = REQ_INSERT;
    r.key      = k;
    r.tag      = t;
    r.hold     = 1'b0;
    r.no_gap   = calm;
    pend_q.push_back(r);
    n_items++;
  endtask

  // Key and tag fields carry random bits; the block ignores them on emit
  task automatic add_emit(bit calm);
    request_t r;
    r.req_type = REQ_EMIT;
    r.key      = key_t'($urandom);
    r.tag      = tag_t'($urandom_range(0, 127));
    r.hold     = 1'b0;
    r.no_gap   = calm;
    pend_q.push_back(r);
    n_items++;
  endtask

  task automatic add_hold();
    request_t r;
    r.req_type = REQ_EMIT;
    r.key      = '0;
    r.tag      = '0;
    r.hold     = 1'b1;
    r.no_gap   = 1'b0;
    pend_q.push_back(r);
  endtask

  // Mix of wide keys, a narrow band that repeats often, and the extremes
  function automatic key_t draw_key();
    case ($urandom_range(0, 4))
      0, 1:    return key_t'($urandom);
      2:       return key_t'($urandom_range(0, 6)) - 3;
      3: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return -1;
          default: return 0;
        endcase
      end
      default: return key_t'($urandom_range(0, 2)) * 1000;
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    int n_ins;
    int n_emit;
    bit calm;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.sort_key = '0;
    req_if.tag_in   = '0;
    rsp_if.ready    = 1'b0;
    fail_cnt  = 0;
    cycle_cnt = 0;
    n_items   = 0;
    rst = 1'b1;

    // Directed: empty emit, extremes, equal keys in arrival order, last flag
    add_emit(1'b0);
    add_insert(KEY_MIN, 7'd0, 1'b0);
    add_insert(KEY_MAX, 7'd127, 1'b0);
    add_insert(32'sd0, 7'd5, 1'b1);
    add_insert(-32'sd1, 7'd1, 1'b1);
    add_insert(32'sd0, 7'd9, 1'b0);
    add_insert(32'sd0, 7'd3, 1'b0);
    repeat (7) add_emit(1'b0);
    add_insert(32'sd1, 7'h55, 1'b0);
    add_emit(1'b1);
    add_emit(1'b1);
    add_hold();

    // Fill past capacity, then drain past empty
    for (int i = 0; i < CAP + 2; i++)
      add_insert(draw_key(), tag_t'($urandom_range(0, 127)), i < CAP / 2);
    for (int i = 0; i < CAP + 1; i++) add_emit(i >= CAP / 2);
    add_hold();

    // Random bursts of inserts and emits, with some noise beats
    while (n_items < 800) begin
      calm   = ($urandom_range(0, 4) == 0);
      n_ins  = $urandom_range(1, 12);
      n_emit = $urandom_range(1, n_ins + 2);
      for (int i = 0; i < n_ins; i++)
        add_insert(draw_key(), tag_t'($urandom_range(0, 127)), calm);
      for (int i = 0; i < n_emit; i++) add_emit(calm);
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0)
          add_insert(draw_key(), tag_t'($urandom_range(0, 127)), calm);
        else
          add_emit(calm);
      end
      if ($urandom_range(0, 29) == 0) add_hold();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
